FILE: rtl/core/text_terminal_cursor_engine_defines.svh
// assertion helpers for the cursor engine
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_DEFINES_SVH

// same-cycle implication
`define TTCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttce check failed");

// next-cycle implication
`define TTCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttce check failed");

`endif

FILE: rtl/core/ttce_pkg.sv
`timescale 1ns / 1ps

package ttce_pkg;

  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ACTION_W = 3;
  localparam int SCALE_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT        = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_CLEAR      = 2'd2,
    CMD_READ       = 2'd3
  } cmd_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_DRAW    = 3'd1,
    ACT_BLANK   = 3'd2,
    ACT_MOVED   = 3'd3,
    ACT_CLEARED = 3'd4,
    ACT_READ    = 3'd5
  } action_t;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

  localparam logic [SCALE_W-1:0] SCALE_X2 = 3'd2;
  localparam logic [SCALE_W-1:0] SCALE_X3 = 3'd3;
  localparam logic [SCALE_W-1:0] SCALE_X4 = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOCATE,
    OP_SIMPLE,
    OP_FILL,
    OP_PUT,
    OP_TAB,
    OP_READ,
    OP_PUBLISH
  } ttce_op_t;

  typedef struct packed {
    logic put_glyph;
    logic tab;
    logic read;
    logic row_valid;
    logic fill_last;
    logic tab_done;
    logic out_free;
  } ttce_stat_t;

endpackage

FILE: rtl/core/ttce_channels.sv
`timescale 1ns / 1ps

interface ttce_req_if import ttce_pkg::*; #(
  parameter int COL_W = 7,
  parameter int ROW_W = 6
) ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  target_col;
  logic [ROW_W-1:0]  target_row;

  modport source (output valid, command, char_code, target_col, target_row, input ready);
  modport sink   (input valid, command, char_code, target_col, target_row, output ready);
endinterface

interface ttce_rsp_if import ttce_pkg::*; #(
  parameter int COL_W = 7,
  parameter int ROW_W = 6
) ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ROW_W-1:0]    draw_row;
  logic [COL_W-1:0]    draw_col;
  logic [COL_W-1:0]    span;
  logic [CHAR_W-1:0]   glyph;
  logic                scrolled;
  logic [ROW_W-1:0]    cursor_row_out;
  logic [COL_W-1:0]    cursor_col_out;
  logic                status;

  modport source (output valid, action, draw_row, draw_col, span, glyph, scrolled,
                  cursor_row_out, cursor_col_out, status, input ready);
  modport sink   (input valid, action, draw_row, draw_col, span, glyph, scrolled,
                  cursor_row_out, cursor_col_out, status, output ready);
endinterface

FILE: rtl/core/text_terminal_cursor_engine.sv
`timescale 1ns / 1ps

// port    side  handshake     carries
// req     in    valid/ready   command, char_code, target_col, target_row
// rsp     out   valid/ready   action, draw_row, draw_col, span, glyph, scrolled,
//                             cursor_row_out, cursor_col_out, status
// cfg     in    cfg_we        cfg_wdata: text_scale
//
// one transaction at a time: a request is loaded, located, dispatched, then runs any fill
// and put, tab or read states, and is published when the output register is free
// a printable character landing in a row not written since reset, clear or scroll
// first fills that row with spaces, one cell at a time on the single write port
// rst is synchronous: screen blank, cursor and top row at zero, text_scale 1
// a held result does not block the next request from being taken

module text_terminal_cursor_engine import ttce_pkg::*; #(
  parameter int GRID_COLUMNS = 80,
  parameter int GRID_ROWS    = 40,
  parameter int TAB_STOP     = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  ttce_req_if.sink           req,
  ttce_rsp_if.source         rsp
);

  ttce_stat_t stat;
  ttce_op_t   op;

  ttce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .op        (op)
  );

  ttce_dpath #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .TAB_STOP     (TAB_STOP)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .op             (op),
    .stat           (stat),
    .command        (req.command),
    .char_code      (req.char_code),
    .target_col     (req.target_col),
    .target_row     (req.target_row),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .action         (rsp.action),
    .draw_row       (rsp.draw_row),
    .draw_col       (rsp.draw_col),
    .span           (rsp.span),
    .glyph          (rsp.glyph),
    .scrolled       (rsp.scrolled),
    .cursor_row_out (rsp.cursor_row_out),
    .cursor_col_out (rsp.cursor_col_out),
    .status         (rsp.status)
  );

endmodule

FILE: rtl/core/ttce_ctrl.sv
`timescale 1ns / 1ps

module ttce_ctrl import ttce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  ttce_stat_t stat,
  output ttce_op_t   op
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LOCATE   = 8'b0000_0010,
    S_DISPATCH = 8'b0000_0100,
    S_FILL     = 8'b0000_1000,
    S_PUT      = 8'b0001_0000,
    S_TAB      = 8'b0010_0000,
    S_READ     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op         = OP_LOAD;
          state_next = S_LOCATE;
        end
      end
      S_LOCATE: begin
        op         = OP_LOCATE;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.put_glyph) begin
          if (stat.row_valid) begin
            op         = OP_PUT;
            state_next = S_DONE;
          end else begin
            state_next = S_FILL;
          end
        end else if (stat.tab) begin
          op         = OP_TAB;
          state_next = stat.tab_done ? S_DONE : S_TAB;
        end else if (stat.read) begin
          state_next = S_READ;
        end else begin
          op         = OP_SIMPLE;
          state_next = S_DONE;
        end
      end
      S_FILL: begin
        op = OP_FILL;
        if (stat.fill_last) state_next = S_PUT;
      end
      S_PUT: begin
        op         = OP_PUT;
        state_next = S_DONE;
      end
      S_TAB: begin
        op = OP_TAB;
        if (stat.tab_done) state_next = S_DONE;
      end
      S_READ: begin
        op         = OP_READ;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          op         = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/ttce_dpath.sv
`timescale 1ns / 1ps
`include "text_terminal_cursor_engine_defines.svh"

module ttce_dpath import ttce_pkg::*; #(
  parameter int GRID_COLUMNS = 80,
  parameter int GRID_ROWS    = 40,
  parameter int TAB_STOP     = 4,
  parameter int COL_W        = $clog2(GRID_COLUMNS + 1),
  parameter int ROW_W        = $clog2(GRID_ROWS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [SCALE_W-1:0]  cfg_wdata,
  input  ttce_op_t            op,
  output ttce_stat_t          stat,
  input  logic [CMD_W-1:0]    command,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic [COL_W-1:0]    target_col,
  input  logic [ROW_W-1:0]    target_row,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output logic [ACTION_W-1:0] action,
  output logic [ROW_W-1:0]    draw_row,
  output logic [COL_W-1:0]    draw_col,
  output logic [COL_W-1:0]    span,
  output logic [CHAR_W-1:0]   glyph,
  output logic                scrolled,
  output logic [ROW_W-1:0]    cursor_row_out,
  output logic [COL_W-1:0]    cursor_col_out,
  output logic                status
);

  localparam int RING_W = $clog2(GRID_ROWS);
  localparam int FILL_W = $clog2(GRID_COLUMNS);
  localparam int DEPTH  = GRID_COLUMNS * GRID_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int MASK_N = 2 ** COL_W;

  localparam logic [COL_W-1:0] COLS_X1 = COL_W'(GRID_COLUMNS);
  localparam logic [COL_W-1:0] COLS_X2 = COL_W'(GRID_COLUMNS / 2);
  localparam logic [COL_W-1:0] COLS_X3 = COL_W'(GRID_COLUMNS / 3);
  localparam logic [COL_W-1:0] COLS_X4 = COL_W'(GRID_COLUMNS / 4);
  localparam logic [ROW_W-1:0] ROWS_X1 = ROW_W'(GRID_ROWS);
  localparam logic [ROW_W-1:0] ROWS_X2 = ROW_W'(GRID_ROWS / 2);
  localparam logic [ROW_W-1:0] ROWS_X3 = ROW_W'(GRID_ROWS / 3);
  localparam logic [ROW_W-1:0] ROWS_X4 = ROW_W'(GRID_ROWS / 4);

  function automatic logic [MASK_N-1:0] stop_mask_f();
    logic [MASK_N-1:0] m;
    for (int i = 0; i < MASK_N; i++) begin
      m[i] = ((i % TAB_STOP) == 0);
    end
    return m;
  endfunction

  localparam logic [MASK_N-1:0] STOP_MASK = stop_mask_f();

  function automatic logic [RING_W-1:0] ring_of(input logic [ROW_W-1:0]  row,
                                                input logic [RING_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = (ROW_W+1)'(row) + (ROW_W+1)'(top);
    if (sum >= (ROW_W+1)'(GRID_ROWS)) sum = sum - (ROW_W+1)'(GRID_ROWS);
    return sum[RING_W-1:0];
  endfunction

  // latched item
  cmd_t              cmd_q;
  logic [CHAR_W-1:0] char_q;
  logic [COL_W-1:0]  tcol_q;
  logic [ROW_W-1:0]  trow_q;

  // terminal state
  logic [COL_W-1:0]     cursor_col;
  logic [ROW_W-1:0]     cursor_row;
  logic [RING_W-1:0]    top_offset;
  logic [COL_W-1:0]     active_cols;
  logic [ROW_W-1:0]     active_rows;
  logic [GRID_ROWS-1:0] row_valid;

  // working registers
  logic [RING_W-1:0] ring_row;
  logic [FILL_W-1:0] fill_cnt;
  logic [COL_W-1:0]  tab_start;
  action_t           res_action;
  logic [ROW_W-1:0]  res_draw_row;
  logic [COL_W-1:0]  res_draw_col;
  logic [COL_W-1:0]  res_span;
  logic [CHAR_W-1:0] res_glyph;
  logic              res_scrolled;
  logic              res_status;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] mem_q;

  logic              is_bs, is_tab, is_lf, is_cr, is_put, is_set, is_clear, is_read;
  logic              put_glyph;
  logic [CHAR_W-1:0] glyph_code;
  logic              read_in_grid;
  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  rcol;
  logic [COL_W-1:0]  wcol;
  logic [COL_W-1:0]  bs_col;
  logic [COL_W-1:0]  put_col;
  logic              put_wrap;
  logic              tab_can;
  logic [COL_W-1:0]  col_inc;
  logic [COL_W-1:0]  tab_col;
  logic              tab_done;
  logic              tab_wrap;
  logic              set_oob;
  logic              fill_last;
  logic              cur_row_valid;
  logic [ROW_W:0]    row_inc;
  logic              rd_scroll;
  logic [ROW_W-1:0]  rd_row;
  logic [RING_W-1:0] rd_top;
  logic [RING_W-1:0] rd_clear;
  logic              row_down_en;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic              mem_we;
  logic [CHAR_W-1:0] wdata;
  logic [COL_W-1:0]  scale_cols;
  logic [ROW_W-1:0]  scale_rows;

  // decode
  assign is_put    = (cmd_q == CMD_PUT);
  assign is_bs     = is_put && (char_q == CHAR_BS);
  assign is_tab    = is_put && (char_q == CHAR_TAB);
  assign is_lf     = is_put && (char_q == CHAR_LF);
  assign is_cr     = is_put && (char_q == CHAR_CR);
  assign put_glyph = is_put && !is_bs && !is_tab && !is_lf && !is_cr;
  assign is_set    = (cmd_q == CMD_SET_CURSOR);
  assign is_clear  = (cmd_q == CMD_CLEAR);
  assign is_read   = (cmd_q == CMD_READ);

  assign glyph_code   = (char_q == CHAR_NUL) ? CHAR_SPACE : char_q;
  assign read_in_grid = ({1'b0, tcol_q} < (COL_W+1)'(GRID_COLUMNS)) &&
                        ({1'b0, trow_q} < (ROW_W+1)'(GRID_ROWS));
  assign sel_row      = is_read ? (read_in_grid ? trow_q : '0) : cursor_row;
  assign rcol         = read_in_grid ? tcol_q : '0;

  // column arithmetic
  assign bs_col   = (cursor_col != '0) ? cursor_col - COL_W'(1) : cursor_col;
  assign put_col  = cursor_col + COL_W'(1);
  assign put_wrap = (put_col >= active_cols);
  assign tab_can  = (cursor_col < active_cols);
  assign col_inc  = cursor_col + COL_W'(1);
  assign tab_col  = tab_can ? col_inc : cursor_col;
  assign tab_done = !tab_can || (col_inc >= active_cols) || STOP_MASK[col_inc];
  assign tab_wrap = (tab_col >= active_cols);
  assign set_oob  = (tcol_q >= active_cols) || (trow_q >= active_rows);

  assign fill_last     = (fill_cnt == FILL_W'(GRID_COLUMNS - 1));
  assign cur_row_valid = row_valid[ring_row];

  // one row down, scrolling at the bottom
  assign row_inc   = (ROW_W+1)'(cursor_row) + (ROW_W+1)'(1);
  assign rd_scroll = (row_inc >= (ROW_W+1)'(active_rows));
  assign rd_row    = rd_scroll ? active_rows - ROW_W'(1) : row_inc[ROW_W-1:0];
  assign rd_top    = (top_offset == RING_W'(GRID_ROWS - 1)) ? '0 : top_offset + RING_W'(1);
  assign rd_clear  = ring_of(active_rows, top_offset);

  assign row_down_en = ((op == OP_SIMPLE) && is_lf) ||
                       ((op == OP_PUT) && put_wrap) ||
                       ((op == OP_TAB) && tab_done && tab_wrap);

  // cell store addressing
  always_comb begin
    case (op)
      OP_FILL:   wcol = COL_W'(fill_cnt);
      OP_SIMPLE: wcol = bs_col;
      default:   wcol = cursor_col;
    endcase
  end

  assign row_base = ADDR_W'(ring_row) * ADDR_W'(GRID_COLUMNS);
  assign waddr    = row_base + ADDR_W'(wcol);
  assign raddr    = row_base + ADDR_W'(rcol);
  assign wdata    = (op == OP_PUT) ? glyph_code : CHAR_SPACE;
  assign mem_we   = (op == OP_FILL) || (op == OP_PUT) ||
                    ((op == OP_SIMPLE) && is_bs && cur_row_valid) ||
                    ((op == OP_TAB) && tab_can && cur_row_valid);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // scale decode
  always_comb begin
    if (cfg_wdata >= SCALE_X4) begin
      scale_cols = COLS_X4;
      scale_rows = ROWS_X4;
    end else if (cfg_wdata == SCALE_X3) begin
      scale_cols = COLS_X3;
      scale_rows = ROWS_X3;
    end else if (cfg_wdata == SCALE_X2) begin
      scale_cols = COLS_X2;
      scale_rows = ROWS_X2;
    end else begin
      scale_cols = COLS_X1;
      scale_rows = ROWS_X1;
    end
  end

  always_comb begin
    stat.put_glyph = put_glyph;
    stat.tab       = is_tab;
    stat.read      = is_read;
    stat.row_valid = cur_row_valid;
    stat.fill_last = fill_last;
    stat.tab_done  = tab_done;
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  // terminal state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col  <= '0;
      cursor_row  <= '0;
      top_offset  <= '0;
      row_valid   <= '0;
      active_cols <= COLS_X1;
      active_rows <= ROWS_X1;
    end else begin
      if (cfg_we) begin
        active_cols <= scale_cols;
        active_rows <= scale_rows;
      end
      case (op)
        OP_SIMPLE: begin
          if (is_bs) cursor_col <= bs_col;
          if (is_lf) cursor_col <= '0;
          if (is_set && !set_oob) begin
            cursor_col <= tcol_q;
            cursor_row <= trow_q;
          end
          if (is_clear) begin
            cursor_col <= '0;
            cursor_row <= '0;
            top_offset <= '0;
            row_valid  <= '0;
          end
        end
        OP_FILL: begin
          if (fill_last) row_valid[ring_row] <= 1'b1;
        end
        OP_PUT: begin
          cursor_col <= put_wrap ? '0 : put_col;
        end
        OP_TAB: begin
          cursor_col <= (tab_done && tab_wrap) ? '0 : tab_col;
        end
        default: ;
      endcase
      if (row_down_en) begin
        cursor_row <= rd_row;
        if (rd_scroll) begin
          top_offset          <= rd_top;
          row_valid[rd_clear] <= 1'b0;
        end
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd_q    <= cmd_t'(command);
        char_q   <= char_code;
        tcol_q   <= target_col;
        trow_q   <= target_row;
        fill_cnt <= '0;
      end
      OP_LOCATE: begin
        ring_row     <= ring_of(sel_row, top_offset);
        tab_start    <= cursor_col;
        res_action   <= ACT_NONE;
        res_draw_row <= '0;
        res_draw_col <= '0;
        res_span     <= '0;
        res_glyph    <= '0;
        res_scrolled <= 1'b0;
        res_status   <= 1'b0;
      end
      OP_SIMPLE: begin
        if (is_bs) begin
          res_action   <= ACT_BLANK;
          res_draw_row <= cursor_row;
          res_draw_col <= bs_col;
          res_span     <= COL_W'(1);
        end
        if (is_lf) res_action <= ACT_MOVED;
        if (is_set) begin
          if (set_oob) res_status <= 1'b1;
          else         res_action <= ACT_MOVED;
        end
        if (is_clear) res_action <= ACT_CLEARED;
      end
      OP_FILL: begin
        fill_cnt <= fill_cnt + FILL_W'(1);
      end
      OP_PUT: begin
        res_action   <= ACT_DRAW;
        res_draw_row <= cursor_row;
        res_draw_col <= cursor_col;
        res_glyph    <= glyph_code;
      end
      OP_TAB: begin
        res_action   <= ACT_BLANK;
        res_draw_row <= cursor_row;
        res_draw_col <= tab_start;
        if (tab_done) res_span <= tab_col - tab_start;
      end
      OP_READ: begin
        res_action   <= ACT_READ;
        res_draw_row <= trow_q;
        res_draw_col <= tcol_q;
        res_glyph    <= !read_in_grid ? '0 : (cur_row_valid ? mem_q : CHAR_SPACE);
      end
      default: ;
    endcase
    if (row_down_en && rd_scroll) res_scrolled <= 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (op == OP_PUBLISH) begin
      action         <= res_action;
      draw_row       <= res_draw_row;
      draw_col       <= res_draw_col;
      span           <= res_span;
      glyph          <= res_glyph;
      scrolled       <= res_scrolled;
      cursor_row_out <= cursor_row;
      cursor_col_out <= cursor_col;
      status         <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (op == OP_PUBLISH) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  `TTCE_ASSERT_IMPL(a_col_in_grid, clk, rst, 1'b1, cursor_col < COL_W'(GRID_COLUMNS))
  `TTCE_ASSERT_IMPL(a_top_in_ring, clk, rst, 1'b1, {1'b0, top_offset} < (RING_W+1)'(GRID_ROWS))
  `TTCE_ASSERT_IMPL(a_fill_fresh_row, clk, rst, op == OP_FILL, !cur_row_valid)
  `TTCE_ASSERT_NEXT(a_fill_marks_row, clk, rst, op == OP_FILL && fill_last, cur_row_valid)

endmodule
